/* sv/bhs_pkg.sv */
// Shared types, constants and helpers for the bilinear height-map sampler.
// No dependencies; imported by every module of the block but bhs_ram.
package bhs_pkg;

    localparam int MAP_WIDTH  = 160;
    localparam int MAP_HEIGHT = 120;
    localparam int MAP_MAX    = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;

    // Texel coordinate width, wide enough for either axis
    localparam int COORD_W = $clog2(MAP_MAX);

    localparam logic [COORD_W-1:0] COL_LAST = COORD_W'(MAP_WIDTH - 1);
    localparam logic [COORD_W-1:0] ROW_LAST = COORD_W'(MAP_HEIGHT - 1);

    // Four banks split by column parity and row parity
    localparam int NUM_BANKS  = 4;
    localparam int BANK_COLS  = (MAP_WIDTH + 1) / 2;
    localparam int BANK_ROWS  = (MAP_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // Field widths
    localparam int POS_W    = 24;
    localparam int SCALE_W  = 20;
    localparam int PROD_W   = POS_W + SCALE_W;
    localparam int WHOLE_W  = PROD_W - 24;
    localparam int FRAC_W   = 8;
    localparam int TEXEL_W  = 8;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 7;
    localparam int HEIGHT_W = 17;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd65536;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 4'd1;

    // Opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Division by 255: floor(2^32 / 255), exact after one correction step
    localparam logic [23:0]          HEIGHT_MAX  = 24'd255;
    localparam logic [23:0]          ROUND_HALF  = 24'd127;
    localparam logic [24:0]          RECIP_255   = 25'h1010101;
    localparam int                   RECIP_SHIFT = 32;
    localparam logic [HEIGHT_W-1:0]  HEIGHT_ONE  = 17'd65536;

    typedef struct packed {
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        logic [FRAC_W-1:0]  frac;
    } coord_t;

    typedef struct packed {
        logic               valid;
        logic [FRAC_W-1:0]  fx;
        logic [FRAC_W-1:0]  fy;
        logic [TEXEL_W-1:0] z11;
        logic [TEXEL_W-1:0] z21;
        logic [TEXEL_W-1:0] z12;
        logic [TEXEL_W-1:0] z22;
    } blend_in_t;

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [COORD_W-1:0] col,
                                                     input logic [COORD_W-1:0] row);
        logic [2*COORD_W-1:0] full;
        full = (2*COORD_W)'(row >> 1) * (2*COORD_W)'(BANK_COLS)
             + (2*COORD_W)'(col >> 1);
        return full[BANK_AW-1:0];
    endfunction

endpackage

/* sv/bilinear_heightmap_sampler.sv */
// Top level of the bilinear height-map sampler: input stages, banked texel store,
// neighbor selection and output. Depends on bhs_pkg, bhs_ram, bhs_coord, bhs_blend.
//
//  channel   signals                                                 direction
//  -------   ------------------------------------------------------  ---------
//  in        in_valid/in_ready, opcode, texel_col, texel_row,        to block
//            texel_value, pos_x, pos_y
//  out       out_valid/out_ready, height                             from block
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data                to block
//
// One transaction per cycle is accepted while the output is not stalled; a sample
// gives a height, a load gives no result. Four texel banks (column/row parity) give
// the four neighbors in one read. A stall at the output freezes the whole pipeline.
// Reset clears valid bits and sets both scales to 1.0; the texel store is not cleared.
module bilinear_heightmap_sampler
    import bhs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic [COL_W-1:0]     texel_col,
    input  logic [ROW_W-1:0]     texel_row,
    input  logic [TEXEL_W-1:0]   texel_value,
    input  logic [POS_W-1:0]     pos_x,
    input  logic [POS_W-1:0]     pos_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [HEIGHT_W-1:0]  height,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SCALE_W-1:0]   cfg_data
);

    logic               en;
    logic [SCALE_W-1:0] scale_x_reg;
    logic [SCALE_W-1:0] scale_y_reg;

    // stages 1 and 2: load fields travel beside the coordinate units
    logic               v1_reg, v2_reg, v3_reg;
    logic               op1_reg, op2_reg;
    logic [COL_W-1:0]   col1_reg, col2_reg;
    logic [ROW_W-1:0]   row1_reg, row2_reg;
    logic [TEXEL_W-1:0] val1_reg, val2_reg;
    coord_t             cx, cy;

    // stage 3: parities and fractions matching the bank read data
    logic               xlo3_reg, xhi3_reg, ylo3_reg, yhi3_reg;
    logic [FRAC_W-1:0]  fx3_reg, fy3_reg;

    logic               load_hit;
    logic [1:0]         load_bank;
    logic [BANK_AW-1:0] load_addr;
    logic [NUM_BANKS-1:0] bank_we;
    logic [TEXEL_W-1:0] bank_q [NUM_BANKS];
    blend_in_t          blend_in;

    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg <= SCALE_RESET;
            scale_y_reg <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_SCALE_X)
            begin
                scale_x_reg <= cfg_data;
            end
            if (cfg_index == CFG_SCALE_Y)
            begin
                scale_y_reg <= cfg_data;
            end
        end
    end

    bhs_coord u_coord_x (
        .clk   (clk),
        .en    (en),
        .pos   (pos_x),
        .scale (scale_x_reg),
        .last  (COL_LAST),
        .coord (cx)
    );

    bhs_coord u_coord_y (
        .clk   (clk),
        .en    (en),
        .pos   (pos_y),
        .scale (scale_y_reg),
        .last  (ROW_LAST),
        .coord (cy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && (op2_reg == OP_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg  <= opcode;
            col1_reg <= texel_col;
            row1_reg <= texel_row;
            val1_reg <= texel_value;
            op2_reg  <= op1_reg;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
            val2_reg <= val1_reg;
            xlo3_reg <= cx.lo[0];
            xhi3_reg <= cx.hi[0];
            ylo3_reg <= cy.lo[0];
            yhi3_reg <= cy.hi[0];
            fx3_reg  <= cx.frac;
            fy3_reg  <= cy.frac;
        end
    end

    // loads outside the map are dropped
    assign load_hit  = v2_reg && (op2_reg == OP_LOAD)
                    && (32'(col2_reg) < 32'(MAP_WIDTH)) && (32'(row2_reg) < 32'(MAP_HEIGHT));
    assign load_bank = {row2_reg[0], col2_reg[0]};
    assign load_addr = bank_addr(COORD_W'(col2_reg), COORD_W'(row2_reg));

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        localparam logic [1:0] BID = 2'(b);
        logic [COORD_W-1:0] rd_col;
        logic [COORD_W-1:0] rd_row;

        // each bank serves whichever neighbor column/row has its parity
        assign rd_col     = (cx.lo[0] == BID[0]) ? cx.lo : cx.hi;
        assign rd_row     = (cy.lo[0] == BID[1]) ? cy.lo : cy.hi;
        assign bank_we[b] = en && load_hit && (load_bank == BID);

        bhs_ram #(
            .WIDTH (TEXEL_W),
            .DEPTH (BANK_DEPTH),
            .AW    (BANK_AW)
        ) u_ram (
            .clk     (clk),
            .we      (bank_we[b]),
            .wr_addr (load_addr),
            .wr_data (val2_reg),
            .re      (en),
            .rd_addr (bank_addr(rd_col, rd_row)),
            .rd_data (bank_q[b])
        );
    end

    // at a clamped edge lo and hi share a parity, so both taps pick the same bank
    always_comb
    begin
        blend_in.valid = v3_reg;
        blend_in.fx    = fx3_reg;
        blend_in.fy    = fy3_reg;
        blend_in.z11   = bank_q[{ylo3_reg, xlo3_reg}];
        blend_in.z21   = bank_q[{ylo3_reg, xhi3_reg}];
        blend_in.z12   = bank_q[{yhi3_reg, xlo3_reg}];
        blend_in.z22   = bank_q[{yhi3_reg, xhi3_reg}];
    end

    bhs_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .blend_in  (blend_in),
        .out_valid (out_valid),
        .height    (height)
    );

`ifndef SYNTHESIS
    a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bank_we))
        else $error("more than one texel bank written in a cycle");

    a_write_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_we != '0) |-> (v2_reg && (op2_reg == OP_LOAD) && en))
        else $error("texel write without a load in the write stage");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v2_reg) && $stable(v3_reg) && $stable(op2_reg)))
        else $error("pipeline moved during an output stall");

    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (height <= HEIGHT_ONE))
        else $error("height above 1.0");
`endif

endmodule

/* sv/bhs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4800,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/bhs_coord.sv */
// One axis of world-to-texel mapping: scale multiply, then clamp and fraction.
// Two register stages. Depends on bhs_pkg.
module bhs_coord
    import bhs_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [POS_W-1:0]   pos,
    input  logic [SCALE_W-1:0] scale,
    input  logic [COORD_W-1:0] last,
    output coord_t             coord
);

    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [WHOLE_W-1:0] whole;
    coord_t             coord_reg;
    coord_t             coord_next;

    assign prod_next = PROD_W'(pos) * PROD_W'(scale);
    assign whole     = prod_reg[PROD_W-1:24];

    always_comb
    begin
        coord_next.lo   = (whole > WHOLE_W'(last)) ? last : whole[COORD_W-1:0];
        coord_next.hi   = (coord_next.lo == last) ? last : coord_next.lo + 1'b1;
        coord_next.frac = prod_reg[23:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

/* sv/bhs_blend.sv */
// Bilinear blend of four texels and rounded division by 255.
// Four register stages, the last being the output register. Depends on bhs_pkg.
module bhs_blend
    import bhs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  blend_in_t           blend_in,
    output logic                out_valid,
    output logic [HEIGHT_W-1:0] height
);

    // stage 4: row blends
    logic                v4_reg;
    logic [FRAC_W-1:0]   fy4_reg;
    logic [15:0]         r1_reg, r1_next;
    logic [15:0]         r2_reg, r2_next;
    logic [8:0]          inv_x, inv_y;
    // stage 5: column blend
    logic                v5_reg;
    logic [23:0]         z_reg, z_next;
    // stage 6: reciprocal estimate
    logic                v6_reg;
    logic [23:0]         n_reg, n_next;
    logic [48:0]         q_prod;
    logic [HEIGHT_W-1:0] qest_reg, qest_next;
    // stage 7: correction
    logic                v7_reg;
    logic [24:0]         rem;
    logic [HEIGHT_W-1:0] height_reg, height_next;

    assign inv_x   = 9'd256 - 9'(blend_in.fx);
    assign r1_next = 16'(17'(inv_x) * 17'(blend_in.z11) + 17'(blend_in.fx) * 17'(blend_in.z21));
    assign r2_next = 16'(17'(inv_x) * 17'(blend_in.z12) + 17'(blend_in.fx) * 17'(blend_in.z22));

    assign inv_y  = 9'd256 - 9'(fy4_reg);
    assign z_next = 24'(25'(inv_y) * 25'(r1_reg) + 25'(fy4_reg) * 25'(r2_reg));

    assign n_next    = z_reg + ROUND_HALF;
    assign q_prod    = 49'(n_next) * 49'(RECIP_255);
    assign qest_next = q_prod[RECIP_SHIFT +: HEIGHT_W];

    // estimate is exact or one low
    assign rem         = 25'(n_reg) - {qest_reg, 8'b0} + 25'(qest_reg);
    assign height_next = (rem >= 25'(HEIGHT_MAX)) ? qest_reg + 1'b1 : qest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= blend_in.valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fy4_reg    <= blend_in.fy;
            r1_reg     <= r1_next;
            r2_reg     <= r2_next;
            z_reg      <= z_next;
            n_reg      <= n_next;
            qest_reg   <= qest_next;
            height_reg <= height_next;
        end
    end

    assign out_valid = v7_reg;
    assign height    = height_reg;

endmodule
